// ===== rtl/rwu_pkg.sv =====
// Shared types and constants for the RMSProp weight update core.
package rwu_pkg;

    localparam logic [15:0] DECAY_RESET = 16'd58982;
    localparam logic [15:0] STEP_RESET  = 16'd655;

    // Configuration register indexes
    localparam logic [15:0] REG_DECAY = 16'd0;
    localparam logic [15:0] REG_STEP  = 16'd1;

    // Square root produces 25 result bits; the quotient has 47 bits
    localparam int SQRT_STEPS = 25;
    localparam int DIV_BITS   = 47;
    localparam int CELLS      = SQRT_STEPS + DIV_BITS;

    typedef struct packed {
        logic signed [31:0] weight;
        logic [31:0]        avg_in;
        logic [31:0]        avg;
        logic               neg;
        logic               frz;
        logic [46:0]        num;
        logic [48:0]        rad;
        logic [49:0]        root;
        logic [25:0]        rem;
        logic [46:0]        quo;
    } rwu_pkt_t;

endpackage

// ===== rtl/rwu_front.sv =====
// Front stages: squares the gradient, scales it and forms the new average.
module rwu_front
    import rwu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] weight_in,
    input  logic [31:0]        average_in,
    input  logic signed [31:0] gradient,
    input  logic               frozen,
    input  logic [15:0]        decay_rate,
    input  logic [15:0]        step_rate,
    output logic               out_valid,
    output rwu_pkt_t           out_pkt
);

    logic               a_valid_reg;
    logic signed [31:0] a_weight_reg;
    logic [31:0]        a_avg_in_reg;
    logic               a_neg_reg;
    logic               a_frz_reg;
    logic [62:0]        a_sq_reg;
    logic [46:0]        a_num_reg;
    logic [31:0]        mag;
    logic               b_valid_reg;
    rwu_pkt_t           b_pkt_reg;
    rwu_pkt_t           b_pkt_next;
    logic [63:0]        sum;
    logic [31:0]        avg;

    // Magnitude of the gradient
    assign mag = gradient[31] ? 32'(-gradient) : 32'(gradient);

    // Stage A: square and scale by the step rate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
        if (en) begin
            a_weight_reg <= weight_in;
            a_avg_in_reg <= average_in;
            a_neg_reg    <= gradient[31];
            a_frz_reg    <= frozen;
            a_sq_reg     <= 63'(mag) * 63'(mag);
            a_num_reg    <= 47'(step_rate) * 47'(mag);
        end
    end

    // Stage B: blend old average with the square, saturate
    always_comb begin
        sum = 64'(decay_rate) * 64'(a_avg_in_reg)
            + 64'(17'd65536 - 17'(decay_rate)) * 64'(a_sq_reg[62:16]);
        avg = (|sum[63:48]) ? 32'hFFFF_FFFF : sum[47:16];
        b_pkt_next        = '0;
        b_pkt_next.weight = a_weight_reg;
        b_pkt_next.avg_in = a_avg_in_reg;
        b_pkt_next.avg    = avg;
        b_pkt_next.neg    = a_neg_reg;
        b_pkt_next.frz    = a_frz_reg;
        b_pkt_next.num    = a_num_reg;
        b_pkt_next.rad    = {(33'(avg) + 33'd1), 16'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            b_pkt_reg <= b_pkt_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_pkt   = b_pkt_reg;

endmodule

// ===== rtl/rwu_sqrt_cell.sv =====
// One square root cell: settles one result bit of the root.
module rwu_sqrt_cell
    import rwu_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  rwu_pkt_t in_pkt,
    output logic     out_valid,
    output rwu_pkt_t out_pkt
);

    localparam logic [49:0] BIT = 50'(1) << (2 * K);

    logic     valid_reg;
    rwu_pkt_t pkt_reg;
    rwu_pkt_t pkt_next;
    logic [49:0] trial;

    // Subtract the trial value when it fits, shift the root
    always_comb begin
        pkt_next = in_pkt;
        trial    = in_pkt.root + BIT;
        if ({1'b0, in_pkt.rad} >= trial) begin
            pkt_next.rad  = in_pkt.rad - trial[48:0];
            pkt_next.root = (in_pkt.root >> 1) + BIT;
        end else begin
            pkt_next.root = in_pkt.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            pkt_reg <= pkt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pkt   = pkt_reg;

endmodule

// ===== rtl/rwu_div_cell.sv =====
// One divider cell: settles one quotient bit of num / root.
module rwu_div_cell
    import rwu_pkg::*;
#(
    parameter int B = 0
)
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  rwu_pkt_t in_pkt,
    output logic     out_valid,
    output rwu_pkt_t out_pkt
);

    logic     valid_reg;
    rwu_pkt_t pkt_reg;
    rwu_pkt_t pkt_next;
    logic [26:0] rem_sh;
    logic [26:0] den;

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
        pkt_next = in_pkt;
        rem_sh   = {in_pkt.rem, in_pkt.num[B]};
        den      = {2'b00, in_pkt.root[24:0]};
        if (rem_sh >= den) begin
            pkt_next.rem    = 26'(rem_sh - den);
            pkt_next.quo[B] = 1'b1;
        end else begin
            pkt_next.rem    = rem_sh[25:0];
            pkt_next.quo[B] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            pkt_reg <= pkt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pkt   = pkt_reg;

endmodule

// ===== rtl/rmsprop_weight_update_core.sv =====
// Top level of the RMSProp weight update core.
//
// Input channel s_*: one weight, its squared-gradient average, the gradient
// and a freeze flag per transaction. Result channel m_*: updated weight,
// updated average and the applied change, one result per input transaction,
// in order. Configuration: cfg_we with cfg_index 0 (decay) or 1 (step rate)
// writes cfg_wdata at the clock edge; other indexes are ignored.
// There are two front stages (square, blend), 25 square root cells, 47 divider
// cells and one output stage between input accept and result valid. Throughput
// is one transaction per cycle while the receiver does not stall; the depth is
// set by the one-bit-per-cell root and quotient chains.
// When the receiver stalls with a result pending, the whole chain holds and
// s_ready drops; it rises again the cycle m_ready is seen.
// Synchronous reset empties the chain and restores decay 58982 and step
// rate 655.
module rmsprop_weight_update_core
    import rwu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_weight_in,
    input  logic [31:0]        s_average_in,
    input  logic signed [31:0] s_gradient,
    input  logic               s_frozen,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_weight_out,
    output logic [31:0]        m_average_out,
    output logic signed [31:0] m_weight_change
);

    logic [15:0] decay_reg;
    logic [15:0] step_reg;
    logic        en;
    logic        vld [0:CELLS];
    rwu_pkt_t    pkt [0:CELLS];
    logic        m_valid_reg;
    logic signed [31:0] weight_reg;
    logic [31:0]        average_reg;
    logic signed [31:0] change_reg;
    logic signed [31:0] weight_next;
    logic [31:0]        average_next;
    logic signed [31:0] change_next;
    logic signed [47:0] ch48;
    logic signed [31:0] change_sat;
    logic signed [32:0] nw33;
    rwu_pkt_t           last;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= DECAY_RESET;
            step_reg  <= STEP_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_DECAY) begin
                decay_reg <= cfg_wdata;
            end else if (cfg_index == REG_STEP) begin
                step_reg <= cfg_wdata;
            end
        end
    end

    // Advance the chain unless a result waits and m_ready is low
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    rwu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .weight_in  (s_weight_in),
        .average_in (s_average_in),
        .gradient   (s_gradient),
        .frozen     (s_frozen),
        .decay_rate (decay_reg),
        .step_rate  (step_reg),
        .out_valid  (vld[0]),
        .out_pkt    (pkt[0])
    );

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        rwu_sqrt_cell #(.K(SQRT_STEPS - 1 - i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld[i]),
            .in_pkt    (pkt[i]),
            .out_valid (vld[i+1]),
            .out_pkt   (pkt[i+1])
        );
    end

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        rwu_div_cell #(.B(DIV_BITS - 1 - j)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld[SQRT_STEPS+j]),
            .in_pkt    (pkt[SQRT_STEPS+j]),
            .out_valid (vld[SQRT_STEPS+j+1]),
            .out_pkt   (pkt[SQRT_STEPS+j+1])
        );
    end

    // Sign, saturate and apply the change
    always_comb begin
        last = pkt[CELLS];
        ch48 = last.neg ? -$signed({1'b0, last.quo}) : $signed({1'b0, last.quo});
        if (ch48 > 48'sd2147483647) begin
            change_sat = 32'sh7FFF_FFFF;
        end else if (ch48 < -48'sd2147483648) begin
            change_sat = 32'sh8000_0000;
        end else begin
            change_sat = ch48[31:0];
        end
        nw33 = 33'(last.weight) + 33'(change_sat);
        if (nw33[32] != nw33[31]) begin
            weight_next = nw33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            weight_next = nw33[31:0];
        end
        average_next = last.avg;
        change_next  = change_sat;
        if (last.frz) begin
            weight_next  = last.weight;
            average_next = last.avg_in;
            change_next  = '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld[CELLS];
        end
        if (en) begin
            weight_reg  <= weight_next;
            average_reg <= average_next;
            change_reg  <= change_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_weight_out    = weight_reg;
    assign m_average_out   = average_reg;
    assign m_weight_change = change_reg;

`ifndef SYNTHESIS
    // Chain may move only when the output slot is free or drains
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output slot");

    // Reset empties the output slot
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Divisor is at least 256 whenever it enters the divider
    a_den_min: assert property (@(posedge aclk) disable iff (!aresetn)
        vld[SQRT_STEPS] |-> (pkt[SQRT_STEPS].root[24:0] >= 25'd256))
        else $error("square root below 256");
`endif

endmodule
